// ----- hdl/hwcp_pkg.sv -----
// Shared types, codes and defaults of the histogram with cumulative percent.
`default_nettype none

package hwcp_pkg;

   localparam int MAX_BINS_DEF   = 16;
   localparam int COUNT_BITS_DEF = 32;
   localparam int ALU_W_DEF      = 44;

   // Action codes of an input transaction.
   localparam logic [1:0] ACT_ADD   = 2'd0;
   localparam logic [1:0] ACT_QUERY = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Configuration register indexes (byte address is four times the index).
   localparam logic [1:0] REG_MIN   = 2'd0;
   localparam logic [1:0] REG_SIZE  = 2'd1;
   localparam logic [1:0] REG_NBINS = 2'd2;

   localparam int CSR_ADDR_W = 4;

   localparam logic [31:0] MIN_RST   = 32'd0;
   localparam logic [30:0] SIZE_RST  = 31'd65536;
   localparam logic [4:0]  NBINS_RST = 5'd16;

   localparam logic [6:0] PCT_FULL = 7'd100;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] sample;
      logic [3:0]         bin_index;
   } req_type;

   typedef struct packed {
      logic [3:0]         hit_bin;
      logic [6:0]         percent;
      logic signed [31:0] edge_value;
   } rsp_type;

   typedef struct packed {
      logic wr_en;
      logic clr;
   } store_ctl_type;

endpackage

`default_nettype wire

// ----- hdl/hwcp_alu.sv -----
// Shared adder and subtractor used by the sum, scaling, division and edge steps of the sequencer.
`default_nettype none

module hwcp_alu #(
   parameter int WIDTH = hwcp_pkg::ALU_W_DEF
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   input  logic             sub,
   output logic [WIDTH-1:0] res,
   output logic             neg
);

   assign res = a + (sub ? ~b : b) + WIDTH'(sub);
   assign neg = res[WIDTH-1];

endmodule

`default_nettype wire

// ----- hdl/hwcp_store.sv -----
// Bin count memory with per-entry valid bits, so reset and clear take effect at once.
`default_nettype none

module hwcp_store #(
   parameter int MAX_BINS   = hwcp_pkg::MAX_BINS_DEF,
   parameter int COUNT_BITS = hwcp_pkg::COUNT_BITS_DEF,
   localparam int BIN_W     = $clog2(MAX_BINS)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  hwcp_pkg::store_ctl_type ctl,
   input  logic [BIN_W-1:0]        rd_addr,
   output logic [COUNT_BITS-1:0]   rd_data,
   input  logic [BIN_W-1:0]        wr_addr,
   input  logic [COUNT_BITS-1:0]   wr_data
);

   logic [COUNT_BITS-1:0] mem_ff [MAX_BINS];
   logic [MAX_BINS-1:0]   valid_ff;
   logic [COUNT_BITS-1:0] rd_q_ff;
   logic                  rd_vld_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_q_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || ctl.clr) begin
         valid_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         if (ctl.wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   // An entry never written since the last clear reads as zero.
   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

// ----- hdl/histogram_with_cumulative_percent.sv -----
// Top level: configuration registers, sequencer and datapath of the histogram.
`default_nettype none

// Histogram of signed Q16.16 samples with underflow and overflow bins. A transaction is
// accepted when start is high and busy is low; busy then stays high while the sequencer
// works, and the result appears on rsp_data with rsp_valid high for exactly one cycle, in
// the first cycle that busy is low again. The receiver cannot stall, so it must take every
// result when it is offered. Sums, scaling, division and edge arithmetic run through one
// shared add/subtract unit. A clear or an unused action never raises busy, and its result
// follows in the cycle after it is accepted. An add subtracts the minimum, then subtracts the
// bin size repeatedly to find the bin (at most the number of bins in use minus two
// subtractions), then reads and writes back the count; a sample below the minimum skips the
// division. A query accumulates the counts from the memory up to the index, scales the sum
// by 100, divides by the total with a restoring divide, and forms the bin edge. Counts come
// back to zero immediately after reset; there is no clearing pass.
module histogram_with_cumulative_percent #(
   parameter int MAX_BINS   = hwcp_pkg::MAX_BINS_DEF,
   parameter int COUNT_BITS = hwcp_pkg::COUNT_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  hwcp_pkg::req_type               req_data,
   output logic                            rsp_valid,
   output hwcp_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hwcp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   localparam int BIN_W = $clog2(MAX_BINS);
   localparam int NB_W  = BIN_W + 1;
   localparam int ALU_A = COUNT_BITS + BIN_W + 8;
   localparam int ALU_B = BIN_W + 33;
   localparam int ALU_W = (ALU_A > ALU_B) ? ALU_A : ALU_B;

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_ADD_DIFF = 4'd1;
   localparam logic [3:0] S_ADD_DIV  = 4'd2;
   localparam logic [3:0] S_INC_RD   = 4'd3;
   localparam logic [3:0] S_INC_WR   = 4'd4;
   localparam logic [3:0] S_Q_SUM    = 4'd5;
   localparam logic [3:0] S_Q_MUL1   = 4'd6;
   localparam logic [3:0] S_Q_MUL2   = 4'd7;
   localparam logic [3:0] S_Q_DIV    = 4'd8;
   localparam logic [3:0] S_E_MUL    = 4'd9;
   localparam logic [3:0] S_E_ADD    = 4'd10;

   localparam logic [2:0] DIV_TOP = 3'd7;

   // Configuration registers.
   logic [31:0] min_ff;
   logic [30:0] size_ff;
   logic [4:0]  nbins_ff;
   logic        csr_wr;
   logic [1:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff   <= hwcp_pkg::MIN_RST;
         size_ff  <= hwcp_pkg::SIZE_RST;
         nbins_ff <= hwcp_pkg::NBINS_RST;
      end else if (csr_wr) begin
         unique case (csr_idx)
            hwcp_pkg::REG_MIN:   min_ff   <= csr_pwdata;
            hwcp_pkg::REG_SIZE:  size_ff  <= csr_pwdata[30:0];
            hwcp_pkg::REG_NBINS: nbins_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         hwcp_pkg::REG_MIN:   csr_prdata = min_ff;
         hwcp_pkg::REG_SIZE:  csr_prdata = {1'b0, size_ff};
         hwcp_pkg::REG_NBINS: csr_prdata = {27'd0, nbins_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // Effective bin count and bin size.
   logic [NB_W-1:0]  n_use;
   logic [BIN_W-1:0] n_m1;
   logic [BIN_W-1:0] n_m2;
   logic [30:0]      size_use;
   logic [BIN_W-1:0] idx_clamp;

   always_comb begin
      if (nbins_ff < 5'd2) begin
         n_use = NB_W'(2);
      end else if (32'(nbins_ff) > 32'(MAX_BINS)) begin
         n_use = NB_W'(MAX_BINS);
      end else begin
         n_use = NB_W'(nbins_ff);
      end
      n_m1     = BIN_W'(n_use - NB_W'(1));
      n_m2     = BIN_W'(n_use - NB_W'(2));
      size_use = (size_ff == '0) ? 31'd1 : size_ff;
      if (32'(req_data.bin_index) > 32'(n_m1)) begin
         idx_clamp = n_m1;
      end else begin
         idx_clamp = BIN_W'(req_data.bin_index);
      end
   end

   // Sequencer and datapath registers.
   logic [3:0]            state_ff, state_in;
   logic [31:0]           sample_ff, sample_in;
   logic [BIN_W-1:0]      idx_ff, idx_in;
   logic [BIN_W-1:0]      hit_ff, hit_in;
   logic [BIN_W-1:0]      cnt_ff, cnt_in;
   logic [BIN_W-1:0]      esh_ff, esh_in;
   logic                  pend_ff, pend_in;
   logic                  last_ff, last_in;
   logic [ALU_W-1:0]      acc_ff, acc_in;
   logic [ALU_W-1:0]      rem_ff, rem_in;
   logic [ALU_W-1:0]      dv_ff, dv_in;
   logic [2:0]            k_ff, k_in;
   logic [6:0]            q_ff, q_in;
   logic [6:0]            pct_ff, pct_in;
   logic [COUNT_BITS-1:0] total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   hwcp_pkg::rsp_type     rsp_ff, rsp_in;

   // Shared unit and store connections.
   logic [ALU_W-1:0]        alu_a;
   logic [ALU_W-1:0]        alu_b;
   logic                    alu_sub;
   logic [ALU_W-1:0]        alu_res;
   logic                    alu_neg;
   hwcp_pkg::store_ctl_type st_ctl;
   logic [BIN_W-1:0]        rd_addr;
   logic [COUNT_BITS-1:0]   rd_data;
   logic [COUNT_BITS-1:0]   wr_data;

   logic [ALU_W-1:0]  min_ext;
   logic [ALU_W-1:0]  sample_ext;
   logic [6:0]        q_next;
   logic [ALU_W-32:0] edge_top;
   logic [31:0]       edge_sat;

   assign min_ext    = {{(ALU_W-32){min_ff[31]}}, min_ff};
   assign sample_ext = {{(ALU_W-32){sample_ff[31]}}, sample_ff};
   assign q_next     = {q_ff[5:0], ~alu_neg};
   assign edge_top   = alu_res[ALU_W-1:31];

   always_comb begin
      if ((edge_top == '0) || (edge_top == '1)) begin
         edge_sat = alu_res[31:0];
      end else if (alu_res[ALU_W-1]) begin
         edge_sat = 32'h8000_0000;
      end else begin
         edge_sat = 32'h7FFF_FFFF;
      end
   end

   hwcp_alu #(
      .WIDTH (ALU_W)
   ) u_alu (
      .a   (alu_a),
      .b   (alu_b),
      .sub (alu_sub),
      .res (alu_res),
      .neg (alu_neg)
   );

   hwcp_store #(
      .MAX_BINS   (MAX_BINS),
      .COUNT_BITS (COUNT_BITS)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .ctl     (st_ctl),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_addr (hit_ff),
      .wr_data (wr_data)
   );

   assign wr_data = (rd_data == '1) ? rd_data : rd_data + COUNT_BITS'(1);

   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      idx_in       = idx_ff;
      hit_in       = hit_ff;
      cnt_in       = cnt_ff;
      esh_in       = esh_ff;
      pend_in      = pend_ff;
      last_in      = last_ff;
      acc_in       = acc_ff;
      rem_in       = rem_ff;
      dv_in        = dv_ff;
      k_in         = k_ff;
      q_in         = q_ff;
      pct_in       = pct_ff;
      total_in     = total_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      alu_a        = acc_ff;
      alu_b        = '0;
      alu_sub      = 1'b0;
      st_ctl       = '0;
      rd_addr      = cnt_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               sample_in = req_data.sample;
               idx_in    = idx_clamp;
               acc_in    = '0;
               cnt_in    = '0;
               pend_in   = 1'b0;
               last_in   = 1'b0;
               unique case (req_data.action)
                  hwcp_pkg::ACT_ADD: begin
                     state_in = S_ADD_DIFF;
                  end
                  hwcp_pkg::ACT_QUERY: begin
                     state_in = S_Q_SUM;
                  end
                  hwcp_pkg::ACT_CLEAR: begin
                     st_ctl.clr   = 1'b1;
                     total_in     = '0;
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_in       = '0;
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         S_ADD_DIFF: begin
            alu_a   = sample_ext;
            alu_b   = min_ext;
            alu_sub = 1'b1;
            rem_in  = alu_res;
            if (alu_neg) begin
               hit_in   = '0;
               state_in = S_INC_RD;
            end else begin
               cnt_in   = '0;
               state_in = S_ADD_DIV;
            end
         end

         // Repeated subtraction of the bin size; the count of successful
         // subtractions plus one is the regular bin, capped by the overflow bin.
         S_ADD_DIV: begin
            alu_a   = rem_ff;
            alu_b   = ALU_W'(size_use);
            alu_sub = 1'b1;
            if (cnt_ff == n_m2) begin
               hit_in   = n_m1;
               state_in = S_INC_RD;
            end else if (alu_neg) begin
               hit_in   = cnt_ff + BIN_W'(1);
               state_in = S_INC_RD;
            end else begin
               rem_in = alu_res;
               cnt_in = cnt_ff + BIN_W'(1);
            end
         end

         S_INC_RD: begin
            rd_addr  = hit_ff;
            state_in = S_INC_WR;
         end

         S_INC_WR: begin
            st_ctl.wr_en = 1'b1;
            total_in     = (total_ff == '1) ? total_ff : total_ff + COUNT_BITS'(1);
            rsp_in.hit_bin    = 4'(hit_ff);
            rsp_in.percent    = '0;
            rsp_in.edge_value = '0;
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end

         // One memory read issued per cycle; the data of the previous read
         // is added in the same cycle.
         S_Q_SUM: begin
            rd_addr = cnt_ff;
            alu_b   = ALU_W'(rd_data);
            if (pend_ff) begin
               acc_in = alu_res;
            end
            pend_in = !last_ff;
            if (!last_ff) begin
               if (cnt_ff == idx_ff) begin
                  last_in = 1'b1;
               end else begin
                  cnt_in = cnt_ff + BIN_W'(1);
               end
            end
            if (last_ff && pend_ff) begin
               state_in = S_Q_MUL1;
            end
         end

         // Scale the sum by 100 as 64 + 32 + 4 over two additions.
         S_Q_MUL1: begin
            alu_a    = acc_ff << 6;
            alu_b    = acc_ff << 5;
            rem_in   = alu_res;
            state_in = S_Q_MUL2;
         end

         S_Q_MUL2: begin
            alu_a    = rem_ff;
            alu_b    = acc_ff << 2;
            rem_in   = alu_res;
            dv_in    = ALU_W'(total_ff) << 7;
            k_in     = DIV_TOP;
            q_in     = '0;
            state_in = S_Q_DIV;
         end

         // Restoring division; a quotient of 128 or more saturates at once.
         S_Q_DIV: begin
            alu_a   = rem_ff;
            alu_b   = dv_ff;
            alu_sub = 1'b1;
            if (total_ff == '0) begin
               pct_in   = '0;
               acc_in   = '0;
               cnt_in   = '0;
               esh_in   = idx_ff;
               state_in = S_E_MUL;
            end else if (k_ff == DIV_TOP) begin
               if (!alu_neg) begin
                  pct_in   = hwcp_pkg::PCT_FULL;
                  acc_in   = '0;
                  cnt_in   = '0;
                  esh_in   = idx_ff;
                  state_in = S_E_MUL;
               end else begin
                  dv_in = dv_ff >> 1;
                  k_in  = k_ff - 3'd1;
               end
            end else begin
               if (!alu_neg) begin
                  rem_in = alu_res;
               end
               if (k_ff == 3'd0) begin
                  pct_in   = (q_next > hwcp_pkg::PCT_FULL) ? hwcp_pkg::PCT_FULL : q_next;
                  acc_in   = '0;
                  cnt_in   = '0;
                  esh_in   = idx_ff;
                  state_in = S_E_MUL;
               end else begin
                  q_in  = q_next;
                  dv_in = dv_ff >> 1;
                  k_in  = k_ff - 3'd1;
               end
            end
         end

         // Shift-and-add product of index and bin size, most significant bit first.
         S_E_MUL: begin
            alu_a  = acc_ff << 1;
            alu_b  = esh_ff[BIN_W-1] ? ALU_W'(size_use) : '0;
            acc_in = alu_res;
            esh_in = esh_ff << 1;
            if (cnt_ff == BIN_W'(BIN_W - 1)) begin
               state_in = S_E_ADD;
            end else begin
               cnt_in = cnt_ff + BIN_W'(1);
            end
         end

         S_E_ADD: begin
            alu_a             = acc_ff;
            alu_b             = min_ext;
            rsp_in.hit_bin    = '0;
            rsp_in.percent    = pct_ff;
            rsp_in.edge_value = edge_sat;
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      idx_ff    <= idx_in;
      hit_ff    <= hit_in;
      cnt_ff    <= cnt_in;
      esh_ff    <= esh_in;
      acc_ff    <= acc_in;
      rem_ff    <= rem_in;
      dv_ff     <= dv_in;
      k_ff      <= k_in;
      q_ff      <= q_in;
      pct_ff    <= pct_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire
